@@ hw/rtl/path_resampler_with_heading_core_macros.svh @@
// ----------------------------------------------------------------------------
// Path resampler assertion macros
// Shared assertion wrappers, removable by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PATH_RESAMPLER_WITH_HEADING_CORE_MACROS_SVH
`define PATH_RESAMPLER_WITH_HEADING_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PRH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("prh assertion failed");
`define PRH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("prh implication failed");
`else
`define PRH_ASSERT(lbl, clk, rstn, prop)
`define PRH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/prh_pkg.sv @@
// ----------------------------------------------------------------------------
// Path resampler package
// Widths, constants, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package prh_pkg;
    localparam int DEF_MAX_STEPS   = 63;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int SPACING_W       = 31;
    localparam logic [SPACING_W-1:0] SPACING_RST = 31'd3277;
    localparam int CX_W            = 44;
    localparam int CZ_W            = 34;
    localparam int CORDIC_ITERS    = 30;
    localparam int CI_W            = 5;
    localparam int ANG_W           = 16;
    localparam logic signed [CX_W-1:0] INV_GAIN     = 44'sd652032874;
    localparam logic signed [CZ_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctl;

    function automatic logic [CZ_W-1:0] atan_lut(input logic [CI_W-1:0] idx);
        logic [CZ_W-1:0] v;
        case (idx)
            5'd0:  v = 34'd536870912;
            5'd1:  v = 34'd316933406;
            5'd2:  v = 34'd167458907;
            5'd3:  v = 34'd85004756;
            5'd4:  v = 34'd42667331;
            5'd5:  v = 34'd21354465;
            5'd6:  v = 34'd10679838;
            5'd7:  v = 34'd5340245;
            5'd8:  v = 34'd2670163;
            5'd9:  v = 34'd1335087;
            5'd10: v = 34'd667544;
            5'd11: v = 34'd333772;
            5'd12: v = 34'd166886;
            5'd13: v = 34'd83443;
            5'd14: v = 34'd41722;
            5'd15: v = 34'd20861;
            5'd16: v = 34'd10430;
            5'd17: v = 34'd5215;
            5'd18: v = 34'd2608;
            5'd19: v = 34'd1304;
            5'd20: v = 34'd652;
            5'd21: v = 34'd326;
            5'd22: v = 34'd163;
            5'd23: v = 34'd81;
            5'd24: v = 34'd41;
            5'd25: v = 34'd20;
            5'd26: v = 34'd10;
            5'd27: v = 34'd5;
            5'd28: v = 34'd3;
            5'd29: v = 34'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

@@ hw/rtl/prh_cordic.sv @@
// ----------------------------------------------------------------------------
// Path resampler CORDIC
// One shared shift-add CORDIC stage, iterated in vectoring or rotation mode.
// ----------------------------------------------------------------------------
`include "path_resampler_with_heading_core_macros.svh"
module prh_cordic
    import prh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cordic_ctl            i_ctl,
    input  logic signed [CX_W-1:0] i_x0,
    input  logic signed [CX_W-1:0] i_y0,
    input  logic signed [CZ_W-1:0] i_z0,
    output logic signed [CX_W-1:0] o_x,
    output logic signed [CX_W-1:0] o_y,
    output logic signed [CZ_W-1:0] o_z,
    output logic                   o_done
);
    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [CZ_W-1:0] r_z, n_z, w_ang;
    logic [CI_W-1:0]        r_iter;
    logic                   r_busy, r_done, r_vect, w_up;

    always_comb begin
        w_xs  = r_x >>> r_iter;
        w_ys  = r_y >>> r_iter;
        w_ang = signed'(atan_lut(r_iter));
        w_up  = r_vect ? !r_y[CX_W-1] : r_z[CZ_W-1];
        n_x   = w_up ? r_x + w_ys : r_x - w_ys;
        n_y   = w_up ? r_y - w_xs : r_y + w_xs;
        n_z   = w_up ? r_z + w_ang : r_z - w_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + CI_W'(1);
                if (r_iter == CI_W'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x    <= i_x0;
            r_y    <= i_y0;
            r_z    <= i_z0;
            r_vect <= i_ctl.vectoring;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

    `PRH_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `PRH_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_ctl.start, !r_busy)
    `PRH_ASSERT_IMPL(a_iter_range, i_clk, i_rst_n, r_busy, r_iter < CI_W'(CORDIC_ITERS))
endmodule

@@ hw/rtl/path_resampler_with_heading_core.sv @@
// A segment goes from its request to its first sample through up to 40 normalization
// shifts, two 30-step passes of the shared CORDIC, the squares, the square root and the
// divisions; each further sample is computed only once the one before has been accepted.
// A held first waypoint is stored with no sample; a lone last waypoint gives its one sample.
// Synchronous active-low reset clears control state and the spacing to 3277.
// ----------------------------------------------------------------------------
// Path resampler with heading
// Resamples waypoint segments at a fixed spacing and tags samples with yaw.
// ----------------------------------------------------------------------------
`include "path_resampler_with_heading_core_macros.svh"
module path_resampler_with_heading_core
    import prh_pkg::*;
#(
    parameter int MAX_STEPS   = DEF_MAX_STEPS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  logic [SPACING_W-1:0]                      i_cfg_wr_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // waypoint_x, waypoint_y
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    input  logic                                      s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // sample_x, sample_y, heading, quat_z, quat_w
    output logic [((2*COORD_WIDTH+55)/8)*8-1:0]       m_axis_tdata,
    output logic                                      m_axis_tlast
);
    localparam int CW     = COORD_WIDTH;
    localparam int SB     = $clog2(MAX_STEPS + 1);
    localparam int OUT_DW = ((2*CW+55)/8)*8;
    localparam int NXW    = (CW + 2 > CX_W) ? CW + 2 : CX_W;
    localparam int NW     = 2*CW + 2;
    localparam int CMPW   = (CW + 1 > SPACING_W + SB) ? CW + 1 : SPACING_W + SB;
    localparam int CNT_W  = $clog2(CW + 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_VEC  = 4'd2;
    localparam logic [3:0] S_SQR  = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_SDIV = 4'd5;
    localparam logic [3:0] S_ODIV = 4'd6;
    localparam logic [3:0] S_QGO  = 4'd7;
    localparam logic [3:0] S_QUAT = 4'd8;
    localparam logic [3:0] S_LOAD = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;

    function automatic logic signed [15:0] to_q14(input logic signed [CX_W-1:0] v);
        logic signed [CX_W-1:0]  t;
        logic signed [CX_W-17:0] r;
        t = v + 44'sd32768;
        r = t[CX_W-1:16];
        if (r > (CX_W-16)'(16384)) begin
            r = (CX_W-16)'(16384);
        end else if (r < -(CX_W-16)'(16384)) begin
            r = -(CX_W-16)'(16384);
        end
        return r[15:0];
    endfunction

    function automatic logic signed [CW:0] floor_q(input logic neg, input logic [CW-1:0] q,
                                                 input logic [SB-1:0] rm);
        logic signed [CW:0] qv;
        qv = $signed({1'b0, q});
        if (!neg) begin
            return qv;
        end else if (rm == '0) begin
            return -qv;
        end
        return -qv - (CW+1)'(1);
    endfunction

    function automatic logic [SB:0] floor_r2(input logic neg, input logic [SB-1:0] rm,
                                            input logic [SB-1:0] st);
        logic [SB-1:0] r;
        r = (neg && rm != '0) ? st - rm : rm;
        return {r, 1'b0};
    endfunction

    logic [3:0]              r_state;
    logic [SPACING_W-1:0]    r_spacing;
    logic                    r_have_prev, r_last, r_seg, r_out_valid, r_olast;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CW-1:0]    r_px, r_py, r_bx, r_by, r_sx, r_sy;
    logic signed [CW:0]      r_dx, r_dy, r_qxinc, r_qyinc, r_ox, r_oy;
    logic signed [NXW-1:0]   r_nx, r_ny;
    logic signed [15:0]      r_h, r_qz, r_qw;
    logic [NW-1:0]           r_max, r_may, r_acc, r_res, r_one;
    logic [CW-1:0]           r_mbx, r_mby, r_dqx, r_dqy;
    logic [CMPW-1:0]         r_rem_s;
    logic [SB-1:0]           r_steps, r_k, r_rmx, r_rmy;
    logic [SB:0]             r_rxinc, r_ryinc, r_orx, r_ory;

    logic signed [CW-1:0]    w_in_x, w_in_y;
    logic signed [CW:0]      w_dx, w_dy, w_ndx, w_ndy;
    logic [CW-1:0]           w_abs_dx, w_abs_dy;
    logic [NXW-1:0]          w_anx, w_any, w_m;
    logic                    w_small, w_big, w_zero, w_accept;
    logic signed [NXW-1:0]   w_prx, w_pry;
    logic signed [CZ_W-1:0]  w_prz;
    t_cordic_ctl             c_ctl;
    logic signed [CX_W-1:0]  c_x0, c_y0, c_x, c_y;
    logic signed [CZ_W-1:0]  c_z0, c_z;
    logic                    c_done;
    logic [CZ_W-1:0]         w_zr;
    logic [NW-1:0]           w_rsum, w_root;
    logic [CMPW-1:0]         w_dsh;
    logic                    w_sge;
    logic [SB:0]             w_qn;
    logic [SB-1:0]           n_steps;
    logic [SB:0]             w_tx, w_ty;
    logic                    w_gx, w_gy;
    logic [SB-1:0]           w_rxn, w_ryn;
    logic [CW-1:0]           w_qxn, w_qyn;
    logic [SB+1:0]           w_tox, w_toy, w_twos;
    logic                    w_cx, w_cy, w_klast;

    assign w_in_x   = s_axis_tdata[CW-1:0];
    assign w_in_y   = s_axis_tdata[2*CW-1:CW];
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_dx     = {w_in_x[CW-1], w_in_x} - {r_px[CW-1], r_px};
    assign w_dy     = {w_in_y[CW-1], w_in_y} - {r_py[CW-1], r_py};
    assign w_ndx    = -r_dx;
    assign w_ndy    = -r_dy;
    assign w_abs_dx = r_dx[CW] ? w_ndx[CW-1:0] : r_dx[CW-1:0];
    assign w_abs_dy = r_dy[CW] ? w_ndy[CW-1:0] : r_dy[CW-1:0];
    assign w_zero   = (r_dx == '0) && (r_dy == '0);

    always_comb begin
        w_anx   = r_nx[NXW-1] ? -r_nx : r_nx;
        w_any   = r_ny[NXW-1] ? -r_ny : r_ny;
        w_m     = (w_anx > w_any) ? w_anx : w_any;
        w_small = (w_m[NXW-1:40] == '0);
        w_big   = |w_m[NXW-1:41];
        if (!r_nx[NXW-1]) begin
            w_prx = r_nx;
            w_pry = r_ny;
            w_prz = '0;
        end else if (!r_ny[NXW-1]) begin
            w_prx = r_ny;
            w_pry = -r_nx;
            w_prz = QUARTER_TURN;
        end else begin
            w_prx = -r_ny;
            w_pry = r_nx;
            w_prz = -QUARTER_TURN;
        end
    end

    always_comb begin
        c_ctl.vectoring = (r_state == S_NORM);
        c_ctl.start     = (r_state == S_QGO) ||
                          (r_state == S_NORM && !w_zero && !w_small && !w_big);
        c_x0 = (r_state == S_NORM) ? CX_W'(w_prx) : INV_GAIN;
        c_y0 = (r_state == S_NORM) ? CX_W'(w_pry) : '0;
        c_z0 = (r_state == S_NORM) ? w_prz : {{(CZ_W-31){r_h[15]}}, r_h, 15'b0};
    end

    prh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_ctl),
        .i_x0    (c_x0),
        .i_y0    (c_y0),
        .i_z0    (c_z0),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z),
        .o_done  (c_done)
    );

    always_comb begin
        w_zr   = c_z + CZ_W'(32768);
        w_rsum = r_res + r_one;
        w_root = (r_acc >= w_rsum) ? (r_res >> 1) + r_one : r_res >> 1;
        w_dsh  = CMPW'(r_spacing) << r_cnt;
        w_sge  = (r_rem_s >= w_dsh);
        w_qn   = {r_steps, w_sge};
        if (w_qn == '0) begin
            n_steps = SB'(1);
        end else if (w_qn > (SB+1)'(MAX_STEPS)) begin
            n_steps = SB'(MAX_STEPS);
        end else begin
            n_steps = w_qn[SB-1:0];
        end
        w_tx   = {r_rmx, r_dqx[CW-1]};
        w_ty   = {r_rmy, r_dqy[CW-1]};
        w_gx   = (w_tx >= {1'b0, r_steps});
        w_gy   = (w_ty >= {1'b0, r_steps});
        w_rxn  = w_gx ? SB'(w_tx - {1'b0, r_steps}) : w_tx[SB-1:0];
        w_ryn  = w_gy ? SB'(w_ty - {1'b0, r_steps}) : w_ty[SB-1:0];
        w_qxn  = {r_dqx[CW-2:0], w_gx};
        w_qyn  = {r_dqy[CW-2:0], w_gy};
        w_twos = {1'b0, r_steps, 1'b0};
        w_tox  = {1'b0, r_orx} + {1'b0, r_rxinc};
        w_toy  = {1'b0, r_ory} + {1'b0, r_ryinc};
        w_cx   = (w_tox >= w_twos);
        w_cy   = (w_toy >= w_twos);
        w_klast = (r_k == r_steps - SB'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spacing   <= SPACING_RST;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_seg       <= 1'b0;
            r_last      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spacing <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last      <= s_axis_tlast;
                        r_have_prev <= !s_axis_tlast;
                        if (r_have_prev) begin
                            r_state <= S_NORM;
                        end else if (s_axis_tlast) begin
                            r_seg   <= 1'b0;
                            r_state <= S_QGO;
                        end
                    end
                end
                S_NORM: begin
                    if (w_zero) begin
                        r_cnt   <= CNT_W'(CW - 1);
                        r_state <= S_SQR;
                    end else if (!w_small && !w_big) begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (c_done) begin
                        r_cnt   <= CNT_W'(CW - 1);
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(CW);
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_ROOT: begin
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(SB);
                        r_state <= S_SDIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SDIV: begin
                    if ((r_cnt == CNT_W'(SB) && w_sge) || r_cnt == '0) begin
                        r_cnt   <= CNT_W'(CW - 1);
                        r_state <= S_ODIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_ODIV: begin
                    if (r_cnt == '0) begin
                        r_seg   <= 1'b1;
                        r_state <= S_QGO;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_QGO: begin
                    r_state <= S_QUAT;
                end
                S_QUAT: begin
                    if (c_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_seg) begin
                            if (w_klast) begin
                                r_seg   <= 1'b0;
                                r_state <= r_last ? S_LOAD : S_IDLE;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_px <= w_in_x;
                    r_py <= w_in_y;
                    r_bx <= r_px;
                    r_by <= r_py;
                    r_dx <= w_dx;
                    r_dy <= w_dy;
                    r_nx <= {{(NXW-CW-1){w_dx[CW]}}, w_dx};
                    r_ny <= {{(NXW-CW-1){w_dy[CW]}}, w_dy};
                    r_h  <= '0;
                end
            end
            S_NORM: begin
                if (w_zero) begin
                    r_h   <= '0;
                    r_max <= NW'(w_abs_dx);
                    r_may <= NW'(w_abs_dy);
                    r_mbx <= w_abs_dx;
                    r_mby <= w_abs_dy;
                    r_acc <= '0;
                end else if (w_small) begin
                    r_nx <= r_nx <<< 1;
                    r_ny <= r_ny <<< 1;
                end else if (w_big) begin
                    r_nx <= r_nx >>> 1;
                    r_ny <= r_ny >>> 1;
                end
            end
            S_VEC: begin
                if (c_done) begin
                    r_h   <= w_zr[31:16];
                    r_max <= NW'(w_abs_dx);
                    r_may <= NW'(w_abs_dy);
                    r_mbx <= w_abs_dx;
                    r_mby <= w_abs_dy;
                    r_acc <= '0;
                end
            end
            S_SQR: begin
                r_acc <= r_acc + (r_mbx[0] ? r_max : '0) + (r_mby[0] ? r_may : '0);
                r_max <= r_max << 1;
                r_may <= r_may << 1;
                r_mbx <= r_mbx >> 1;
                r_mby <= r_mby >> 1;
                r_res <= '0;
                r_one <= NW'(1) << (2*CW);
            end
            S_ROOT: begin
                if (r_acc >= w_rsum) begin
                    r_acc <= r_acc - w_rsum;
                end
                r_res   <= w_root;
                r_one   <= r_one >> 2;
                r_steps <= '0;
                if (r_cnt == '0) begin
                    r_rem_s <= CMPW'(w_root[CW:0]);
                end
            end
            S_SDIV: begin
                r_rmx <= '0;
                r_rmy <= '0;
                r_dqx <= w_abs_dx;
                r_dqy <= w_abs_dy;
                if (r_cnt == CNT_W'(SB)) begin
                    if (w_sge) begin
                        r_steps <= SB'(MAX_STEPS);
                    end
                end else begin
                    if (w_sge) begin
                        r_rem_s <= r_rem_s - w_dsh;
                    end
                    if (r_cnt == '0) begin
                        r_steps <= n_steps;
                    end else begin
                        r_steps <= w_qn[SB-1:0];
                    end
                end
            end
            S_ODIV: begin
                r_rmx <= w_rxn;
                r_rmy <= w_ryn;
                r_dqx <= w_qxn;
                r_dqy <= w_qyn;
                if (r_cnt == '0) begin
                    r_qxinc <= floor_q(r_dx[CW], w_qxn, w_rxn);
                    r_qyinc <= floor_q(r_dy[CW], w_qyn, w_ryn);
                    r_rxinc <= floor_r2(r_dx[CW], w_rxn, r_steps);
                    r_ryinc <= floor_r2(r_dy[CW], w_ryn, r_steps);
                    r_ox    <= '0;
                    r_oy    <= '0;
                    r_orx   <= {1'b0, r_steps};
                    r_ory   <= {1'b0, r_steps};
                    r_k     <= '0;
                end
            end
            S_QUAT: begin
                if (c_done) begin
                    r_qz <= to_q14(c_y);
                    r_qw <= to_q14(c_x);
                end
            end
            S_LOAD: begin
                if (r_seg) begin
                    r_sx    <= r_bx + r_ox[CW-1:0];
                    r_sy    <= r_by + r_oy[CW-1:0];
                    r_olast <= w_klast && !r_last;
                end else begin
                    r_sx    <= r_px;
                    r_sy    <= r_py;
                    r_olast <= 1'b1;
                end
            end
            S_WAIT: begin
                if (m_axis_tready && r_seg) begin
                    r_orx <= w_cx ? (SB+1)'(w_tox - w_twos) : w_tox[SB:0];
                    r_ory <= w_cy ? (SB+1)'(w_toy - w_twos) : w_toy[SB:0];
                    r_ox  <= r_ox + r_qxinc + $signed({{CW{1'b0}}, w_cx});
                    r_oy  <= r_oy + r_qyinc + $signed({{CW{1'b0}}, w_cy});
                    r_k   <= r_k + SB'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = OUT_DW'({r_qw, r_qz, r_h, r_sy, r_sx});

    `PRH_ASSERT_IMPL(a_out_in_wait, i_clk, i_rst_n, m_axis_tvalid, r_state == S_WAIT)
    `PRH_ASSERT_IMPL(a_steps_range, i_clk, i_rst_n, r_state == S_LOAD && r_seg,
        r_steps != '0 && r_steps <= SB'(MAX_STEPS) && r_k < r_steps)
    `PRH_ASSERT(a_last_ends_item, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> r_state == S_IDLE)
endmodule
